### rtl/xcpc_pkg.sv
`default_nettype none

package xcpc_pkg;

  localparam int unsigned GenWidth   = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned NumLanes   = 3;
  localparam int unsigned PixWidth   = NumLanes * ByteWidth;
  localparam int unsigned ShiftA     = 13;
  localparam int unsigned ShiftB     = 17;
  localparam int unsigned ShiftC     = 5;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned IdxWidth   = 2;

  typedef enum logic [IdxWidth-1:0] {
    RegSeed  = 2'd0,
    RegStart = 2'd1,
    RegMode  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                 first_pixel;
    logic [ByteWidth-1:0] in_red;
    logic [ByteWidth-1:0] in_green;
    logic [ByteWidth-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [ByteWidth-1:0] out_red;
    logic [ByteWidth-1:0] out_green;
    logic [ByteWidth-1:0] out_blue;
  } pix_out_t;

  typedef struct packed {
    logic accept;
    logic first;
    logic decrypt;
  } lane_ctrl_t;

  function automatic logic [GenWidth-1:0] xs_advance(input logic [GenWidth-1:0] v);
    logic [GenWidth-1:0] a;
    logic [GenWidth-1:0] b;
    a = v ^ (v << ShiftA);
    b = a ^ (a >> ShiftB);
    return b ^ (b << ShiftC);
  endfunction

endpackage

`default_nettype wire

### rtl/xcpc_prng.sv
`default_nettype none

module xcpc_prng (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic                             first_i,
  input  wire logic [xcpc_pkg::GenWidth-1:0]    seed_i,
  output logic      [xcpc_pkg::GenWidth-1:0]    keystream_o,
  output logic      [xcpc_pkg::GenWidth-1:0]    state_o
);

  logic [xcpc_pkg::GenWidth-1:0] gen_d;
  logic [xcpc_pkg::GenWidth-1:0] gen_q;

  always_comb begin
    gen_d = xcpc_pkg::xs_advance(first_i ? seed_i : gen_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (accept_i) begin
      gen_q <= gen_d;
    end
  end

  assign keystream_o = gen_d;
  assign state_o     = gen_q;

endmodule

`default_nettype wire

### rtl/xcpc_lane.sv
`default_nettype none

module xcpc_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire xcpc_pkg::lane_ctrl_t              ctrl_i,
  input  wire logic [xcpc_pkg::ByteWidth-1:0]    start_i,
  input  wire logic [xcpc_pkg::ByteWidth-1:0]    key_i,
  input  wire logic [xcpc_pkg::ByteWidth-1:0]    data_i,
  output logic      [xcpc_pkg::ByteWidth-1:0]    data_o
);

  logic [xcpc_pkg::ByteWidth-1:0] chain_d;
  logic [xcpc_pkg::ByteWidth-1:0] chain_q;
  logic [xcpc_pkg::ByteWidth-1:0] chain_cur;

  always_comb begin
    chain_cur = ctrl_i.first ? start_i : chain_q;
    data_o    = data_i ^ chain_cur ^ key_i;
    chain_d   = ctrl_i.decrypt ? data_i : data_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (ctrl_i.accept) begin
      chain_q <= chain_d;
    end
  end

endmodule

`default_nettype wire

### rtl/xorshift_chained_pixel_cipher_core.sv
`default_nettype none

// Pixel cipher with a 32-bit xorshift (13,17,5) keystream and ciphertext
// chaining. Each transfer on the input carries one RGB pixel; three byte lanes
// XOR it with the chain and the low three keystream bytes, and the result is
// queued in a two-entry output buffer. One pixel is taken every clock cycle
// while the buffer has room; results are registered in the buffer.
// Set first_pixel on the first pixel of an image to reload the generator from
// prng_seed and the chain from start_value. Registers (APB, byte address):
// 0x0 prng_seed, 0x4 start_value, 0x8 decrypt_mode; write them only while idle.
module xorshift_chained_pixel_cipher_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire xcpc_pkg::pix_in_t                  in_pixel_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output xcpc_pkg::pix_out_t                      out_pixel_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [xcpc_pkg::AddrWidth-1:0]     paddr,
  input  wire logic [xcpc_pkg::DataWidth-1:0]     pwdata,
  output logic      [xcpc_pkg::DataWidth-1:0]     prdata,
  output logic                                    pready
);

  localparam int unsigned BW = xcpc_pkg::ByteWidth;

  logic [xcpc_pkg::GenWidth-1:0] seed_q;
  logic [xcpc_pkg::PixWidth-1:0] start_q;
  logic                          mode_q;
  logic                          cfg_wr;
  xcpc_pkg::reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = xcpc_pkg::reg_idx_e'(paddr[xcpc_pkg::AddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      start_q <= '0;
      mode_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        xcpc_pkg::RegSeed:  seed_q  <= pwdata;
        xcpc_pkg::RegStart: start_q <= pwdata[xcpc_pkg::PixWidth-1:0];
        xcpc_pkg::RegMode:  mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      xcpc_pkg::RegSeed:  prdata = seed_q;
      xcpc_pkg::RegStart: prdata = {{(xcpc_pkg::DataWidth-xcpc_pkg::PixWidth){1'b0}}, start_q};
      xcpc_pkg::RegMode:  prdata = {{(xcpc_pkg::DataWidth-1){1'b0}}, mode_q};
      default:            prdata = '0;
    endcase
  end

  logic                          in_acc;
  logic                          out_acc;
  xcpc_pkg::lane_ctrl_t          lane_ctrl;
  logic [xcpc_pkg::GenWidth-1:0] keystream;
  logic [xcpc_pkg::GenWidth-1:0] gen_state;
  logic [xcpc_pkg::PixWidth-1:0] pix_in;
  logic [xcpc_pkg::PixWidth-1:0] pix_out;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign pix_in  = {in_pixel_i.in_red, in_pixel_i.in_green, in_pixel_i.in_blue};

  assign lane_ctrl.accept  = in_acc;
  assign lane_ctrl.first   = in_pixel_i.first_pixel;
  assign lane_ctrl.decrypt = mode_q;

  xcpc_prng u_prng (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .first_i     (in_pixel_i.first_pixel),
    .seed_i      (seed_q),
    .keystream_o (keystream),
    .state_o     (gen_state)
  );

  for (genvar l = 0; l < xcpc_pkg::NumLanes; l++) begin : g_lane
    xcpc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .start_i (start_q[l*BW +: BW]),
      .key_i   (keystream[l*BW +: BW]),
      .data_i  (pix_in[l*BW +: BW]),
      .data_o  (pix_out[l*BW +: BW])
    );
  end

  xcpc_pkg::pix_out_t merged;
  assign merged.out_red   = pix_out[2*BW +: BW];
  assign merged.out_green = pix_out[BW +: BW];
  assign merged.out_blue  = pix_out[0 +: BW];

  xcpc_pkg::pix_out_t buf_q [2];
  logic               wr_ptr_q;
  logic               rd_ptr_q;
  logic [1:0]         count_d;
  logic [1:0]         count_q;

  always_comb begin
    count_d = count_q;
    if (in_acc && !out_acc) begin
      count_d = count_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_acc) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_q[wr_ptr_q] <= merged;
    end
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_pixel_o = buf_q[rd_ptr_q];

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("Output buffer count out of range.");

  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_acc) |=> (count_q == $past(count_q) + 2'd1))
    else $error("Output buffer did not grow on an input transfer.");

  a_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_pixel_i.first_pixel) |=>
      (gen_state == xcpc_pkg::xs_advance($past(seed_q))))
    else $error("Generator not reloaded from the seed on a first pixel.");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("Result dropped without an output transfer.");

endmodule

`default_nettype wire

### test/xorshift_chained_pixel_cipher_core_test.sv
`timescale 1ns / 100ps

module xorshift_chained_pixel_cipher_core_test;

  import xcpc_pkg::*;

  localparam logic [IdxWidth-1:0] SpareIdx = 2'd3;
  localparam int unsigned PhaseItems = 165;

  class pixel_cipher_scoreboard;
    logic [GenWidth-1:0] seed_reg;
    logic [PixWidth-1:0] start_reg;
    bit                  decrypt_reg;
    logic [GenWidth-1:0] keystream;
    logic [PixWidth-1:0] chain;
    pix_out_t            expected_pixels[$];
    int                  errors;
    int                  checked;
    int                  image_starts;
    int                  decrypt_pixels;

    function new();
      seed_reg       = '0;
      start_reg      = '0;
      decrypt_reg    = 1'b0;
      keystream      = '0;
      chain          = '0;
      errors         = 0;
      checked        = 0;
      image_starts   = 0;
      decrypt_pixels = 0;
    endfunction

    function logic [GenWidth-1:0] next_keystream(logic [GenWidth-1:0] v);
      logic [GenWidth-1:0] t;
      t = v ^ (v << ShiftA);
      t = t ^ (t >> ShiftB);
      return t ^ (t << ShiftC);
    endfunction

    function void set_reg(logic [IdxWidth-1:0] idx, logic [DataWidth-1:0] data);
      case (idx)
        RegSeed: begin
          seed_reg = data;
        end
        RegStart: begin
          start_reg = data[PixWidth-1:0];
        end
        RegMode: begin
          decrypt_reg = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_pixel(pix_in_t p);
      logic [PixWidth-1:0] plain;
      logic [PixWidth-1:0] cipher;
      if (p.first_pixel) begin
        keystream = next_keystream(seed_reg);
        chain = start_reg;
        image_starts++;
      end else begin
        keystream = next_keystream(keystream);
      end
      plain  = {p.in_red, p.in_green, p.in_blue};
      cipher = plain ^ chain ^ keystream[PixWidth-1:0];
      chain  = decrypt_reg ? plain : cipher;
      if (decrypt_reg) begin
        decrypt_pixels++;
      end
      expected_pixels.push_back(pix_out_t'(cipher));
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t exp;
      string    lane_name[NumLanes];
      lane_name = '{"out_blue", "out_green", "out_red"};
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected output transfer, actual %h", $time, got);
        errors++;
        return;
      end
      exp = expected_pixels.pop_front();
      checked++;
      for (int k = 0; k < NumLanes; k++) begin
        if (got[ByteWidth*k +: ByteWidth] !== exp[ByteWidth*k +: ByteWidth]) begin
          $display("%0t: %s mismatch, expected %h actual %h", $time, lane_name[k],
                   exp[ByteWidth*k +: ByteWidth], got[ByteWidth*k +: ByteWidth]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready_o;
  pix_in_t              in_pixel;
  logic                 out_valid_o;
  logic                 out_ready;
  pix_out_t             out_pixel_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  int unsigned send_idle;
  int unsigned recv_idle;

  pixel_cipher_scoreboard sb = new();

  xorshift_chained_pixel_cipher_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_pixel_i (in_pixel),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_pixel_o(out_pixel_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("xorshift_chained_pixel_cipher_core_test: done, errors");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      sb.check_pixel(out_pixel_o);
    end
  end

  function automatic logic [ByteWidth-1:0] rand_byte();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(1) ? '1 : '0;
    end
    return ByteWidth'($urandom);
  endfunction

  function automatic pix_in_t make_pixel(logic first, logic [ByteWidth-1:0] r,
                                         logic [ByteWidth-1:0] g, logic [ByteWidth-1:0] b);
    pix_in_t p;
    p.first_pixel = first;
    p.in_red      = r;
    p.in_green    = g;
    p.in_blue     = b;
    return p;
  endfunction

  task automatic send_pixel(input pix_in_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do begin
      @(posedge clk);
    end while (!in_ready_o);
    sb.note_pixel(p);
  endtask

  task automatic send_random(input logic first, input int n);
    for (int k = 0; k < n; k++) begin
      send_pixel(make_pixel(first && (k == 0), rand_byte(), rand_byte(), rand_byte()));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input logic [IdxWidth-1:0] idx, input logic [DataWidth-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [DataWidth-1:0] seed, input logic [DataWidth-1:0] start,
                           input logic [DataWidth-1:0] mode);
    drain();
    apb_write(RegSeed, seed);
    apb_write(RegStart, start);
    apb_write(RegMode, mode);
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle);
    int                   sent;
    int                   len;
    logic [DataWidth-1:0] seed;
    logic                 first;
    pix_in_t              p;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < PhaseItems) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(5))
          0: seed = '0;
          1: seed = '1;
          default: seed = $urandom;
        endcase
        configure(seed, $urandom, $urandom);
      end
      len = $urandom_range(1, 24);
      for (int k = 0; k < len; k++) begin
        if (k == 0) begin
          first = ($urandom_range(9) != 0);
        end else begin
          first = ($urandom_range(29) == 0);
        end
        p = make_pixel(first, rand_byte(), rand_byte(), rand_byte());
        send_pixel(p);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_pixel  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    send_idle = 0;
    recv_idle = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Pixels before any image start run on the reset state.
    send_pixel(make_pixel(1'b0, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF));

    // A zero seed gives an all-zero keystream; the unused register slot is ignored.
    drain();
    apb_write(SpareIdx, '1);
    configure(32'h0000_0000, 32'hFF00_0000, 32'h0000_0000);
    send_pixel(make_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(1'b0, 8'h00, 8'h00, 8'h00));
    send_random(1'b0, 3);

    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_pixel(make_pixel(1'b1, 8'hFF, 8'h00, 8'hFF));
    send_random(1'b0, 4);

    configure(32'h8000_0001, 32'h00A5_5A0F, 32'hFFFF_FFFF);
    send_random(1'b1, 4);

    // Seed and start value written mid-image wait for the next image start,
    // while the mode takes effect on the next transfer.
    configure($urandom, $urandom, 32'h0000_0000);
    send_random(1'b0, 3);
    send_random(1'b1, 2);

    run_phase(10, 63);
    run_phase(63, 10);
    run_phase(0, 0);

    drain();
    repeat (5) @(posedge clk);
    $display("Checked %0d pixels over %0d image starts, %0d of them in decrypt mode,",
             sb.checked, sb.image_starts, sb.decrypt_pixels);
    $display("with idle input, stalled output and back-to-back traffic.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("xorshift_chained_pixel_cipher_core_test: done, clean");
    end else begin
      $display("xorshift_chained_pixel_cipher_core_test: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/xcpc_pkg.sv
rtl/xcpc_prng.sv
rtl/xcpc_lane.sv
rtl/xorshift_chained_pixel_cipher_core.sv
test/xorshift_chained_pixel_cipher_core_test.sv
